### rtl/inode_cache_replacement_top_defines.svh
// Assertion macro for the inode cache replacement engine
`ifndef INODE_CACHE_REPLACEMENT_TOP_DEFINES_SVH
`define INODE_CACHE_REPLACEMENT_TOP_DEFINES_SVH
// concurrent assertion with clock and async reset
`define ICR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`endif

### rtl/icr_pkg.sv
// Package: types and constants of the inode cache replacement engine
`default_nettype none
package icr_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned SlotW = 4;
  localparam int unsigned RecW = 20;
  localparam int unsigned AgeW = 16;
  localparam int unsigned BlkShift = 4;
  localparam int unsigned QDepth = 2;

  localparam logic [1:0] OpLookup = 2'd0;
  localparam logic [1:0] OpInstall = 2'd1;
  localparam logic [1:0] OpFlush = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [2:0] KindHit = 3'd0;
  localparam logic [2:0] KindWb = 3'd1;
  localparam logic [2:0] KindFill = 3'd2;
  localparam logic [2:0] KindInst = 3'd3;
  localparam logic [2:0] KindFlush = 3'd4;

  typedef struct packed {
    logic [1:0] op;
    logic [RecW-1:0] rec;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [SlotW-1:0] slot;
    logic [RecW-1:0] rec;
    logic last;
  } res_t;
endpackage
`default_nettype wire

### rtl/icr_front.sv
// Front end: accepts transactions, drops unused opcodes, queues commands
`default_nettype none
module icr_front (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_valid_i,
  output logic s_ready_o,
  input wire icr_pkg::cmd_t s_cmd_i,
  output logic q_valid_o,
  input wire logic q_ready_i,
  output icr_pkg::cmd_t q_cmd_o
);
  icr_pkg::cmd_t mem_q [icr_pkg::QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;
  logic push, pop, keep;

  assign s_ready_o = (cnt_q != 2'(icr_pkg::QDepth));
  assign keep = s_cmd_i.op inside {icr_pkg::OpLookup, icr_pkg::OpInstall, icr_pkg::OpFlush};
  assign push = s_valid_i && s_ready_o && keep;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_cmd_o = mem_q[rp_q];
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= s_cmd_i;
  end
endmodule
`default_nettype wire

### rtl/icr_back.sv
// Back end: tag match, victim search, writeback scan and result output
`default_nettype none
`include "inode_cache_replacement_top_defines.svh"
module icr_back (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic q_valid_i,
  output logic q_ready_o,
  input wire icr_pkg::cmd_t q_cmd_i,
  output logic m_valid_o,
  input wire logic m_ready_i,
  output icr_pkg::res_t m_res_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMatch = 3'd1;
  localparam logic [2:0] StVict = 3'd2;
  localparam logic [2:0] StScan = 3'd3;
  localparam logic [2:0] StPlace = 3'd4;
  localparam logic [2:0] StFlushDone = 3'd5;

  logic [2:0] st_q, st_d;
  icr_pkg::cmd_t cmd_q;
  logic [icr_pkg::Slots-1:0] vld_q;
  logic [icr_pkg::RecW-1:0] tag_q [icr_pkg::Slots];
  logic [icr_pkg::AgeW-1:0] age_q [icr_pkg::Slots];
  logic [icr_pkg::AgeW-1:0] ctr_q;
  logic [icr_pkg::SlotW-1:0] idx_q, vic_q;
  logic [icr_pkg::RecW-icr_pkg::BlkShift-1:0] blk_q;
  logic ovalid_q;
  icr_pkg::res_t ores_q;

  logic [icr_pkg::Slots-1:0] hitv;
  logic hit;
  logic [icr_pkg::SlotW-1:0] hit_idx, inv_idx, old_idx;
  logic full;
  logic out_free;
  logic out_load, out_set;

  always_comb begin
    hit_idx = '0;
    hit = 1'b0;
    inv_idx = '0;
    for (int i = icr_pkg::Slots - 1; i >= 0; i--) begin
      hitv[i] = vld_q[i] && (tag_q[i] == cmd_q.rec);
      if (hitv[i]) hit_idx = icr_pkg::SlotW'(i);
      if (!vld_q[i]) inv_idx = icr_pkg::SlotW'(i);
    end
    hit = |hitv;
  end
  assign full = &vld_q;
  assign old_idx = (age_q[idx_q] < age_q[vic_q]) ? idx_q : vic_q;

  assign out_free = !ovalid_q || m_ready_i;
  assign q_ready_o = (st_q == StIdle);
  assign m_valid_o = ovalid_q;
  assign m_res_o = ores_q;

  always_comb begin
    out_load = 1'b0;
    out_set = 1'b1;
    case (st_q)
      StMatch: out_load = out_free && (cmd_q.op == icr_pkg::OpLookup) && hit;
      StScan: begin
        out_load = out_free;
        out_set = vld_q[idx_q] && ((cmd_q.op == icr_pkg::OpFlush) ||
            (tag_q[idx_q][icr_pkg::RecW-1:icr_pkg::BlkShift] == blk_q));
      end
      StPlace, StFlushDone: out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (q_valid_i) st_d = (q_cmd_i.op == icr_pkg::OpFlush) ? StScan : StMatch;
      StMatch: begin
        if (cmd_q.op == icr_pkg::OpLookup && hit) begin
          if (out_free) st_d = StIdle;
        end else if (!full) st_d = StPlace;
        else st_d = StVict;
      end
      StVict: if (idx_q == icr_pkg::SlotW'(icr_pkg::Slots - 1)) st_d = StScan;
      StScan: begin
        if (out_free && idx_q == icr_pkg::SlotW'(icr_pkg::Slots - 1))
          st_d = (cmd_q.op == icr_pkg::OpFlush) ? StFlushDone : StPlace;
      end
      StPlace: if (out_free) st_d = StIdle;
      StFlushDone: if (out_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      vld_q <= '0;
      ctr_q <= icr_pkg::AgeW'(1);
      ovalid_q <= 1'b0;
      idx_q <= '0;
      vic_q <= '0;
      for (int i = 0; i < icr_pkg::Slots; i++) age_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (out_load) ovalid_q <= out_set;
      else if (m_ready_i) ovalid_q <= 1'b0;
      case (st_q)
        StIdle: begin
          idx_q <= '0;
          vic_q <= '0;
        end
        StMatch: begin
          if (cmd_q.op == icr_pkg::OpLookup && hit) begin
            if (out_free) age_q[hit_idx] <= ctr_q;
          end else if (!full) vic_q <= inv_idx;
          else idx_q <= icr_pkg::SlotW'(1);
        end
        StVict: begin
          vic_q <= old_idx;
          idx_q <= (idx_q == icr_pkg::SlotW'(icr_pkg::Slots - 1)) ? '0
              : idx_q + icr_pkg::SlotW'(1);
        end
        StScan: begin
          if (out_free) begin
            idx_q <= idx_q + icr_pkg::SlotW'(1);
            if (idx_q == icr_pkg::SlotW'(icr_pkg::Slots - 1) &&
                cmd_q.op != icr_pkg::OpFlush) ctr_q <= ctr_q + icr_pkg::AgeW'(1);
          end
        end
        StPlace: begin
          if (out_free) begin
            vld_q[vic_q] <= 1'b1;
            age_q[vic_q] <= ctr_q;
            ctr_q <= ctr_q + icr_pkg::AgeW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && q_valid_i) cmd_q <= q_cmd_i;
    if (st_q == StVict && idx_q == icr_pkg::SlotW'(icr_pkg::Slots - 1))
      blk_q <= tag_q[old_idx][icr_pkg::RecW-1:icr_pkg::BlkShift];
    if (st_q == StPlace && out_free) tag_q[vic_q] <= cmd_q.rec;
    if (out_free) begin
      case (st_q)
        StMatch: ores_q <= '{kind: icr_pkg::KindHit, slot: hit_idx, rec: cmd_q.rec, last: 1'b1};
        StScan: ores_q <= '{kind: icr_pkg::KindWb, slot: idx_q, rec: tag_q[idx_q], last: 1'b0};
        StPlace: ores_q <= '{kind: (cmd_q.op == icr_pkg::OpLookup) ? icr_pkg::KindFill
            : icr_pkg::KindInst, slot: vic_q, rec: cmd_q.rec, last: 1'b1};
        StFlushDone: ores_q <= '{kind: icr_pkg::KindFlush, slot: '0, rec: '0, last: 1'b1};
        default: ;
      endcase
    end
  end

  `ICR_ASSERT(a_out_hold, ovalid_q && !m_ready_i |=> ovalid_q && $stable(ores_q), "result lost")
  `ICR_ASSERT(a_state_legal, st_q <= StFlushDone, "illegal state")
  `ICR_ASSERT(a_place_valid, (st_q == StPlace) && out_free |=> vld_q[$past(vic_q)], "no valid")
endmodule
`default_nettype wire

### rtl/inode_cache_replacement_top.sv
// Top level of the inode cache replacement engine
// channel  dir  tdata fields (low bit up)          tuser
// s_axis   in   record_number[19:0]                 opcode[1:0]
// m_axis   out  kind[2:0] slot[6:3] slot_record[26:7]   -      tlast=last
// Lookup hit: the result comes from the tag match. Miss with a free slot: the
// record is placed in a free slot.
// Miss with full cache: an age search, then a block scan of all slots, with one
// shared age comparator and one tag read per cycle while the output is free.
// Flush: a scan of all slots, then the flush done result.
// Reset clears valid bits, ages and sets the use counter to one.
// A stalled output holds the engine; the two-entry queue accepts until full.
`default_nettype none
module inode_cache_replacement_top (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input wire logic [23:0] s_axis_tdata, // record_number[19:0]
  input wire logic [1:0] s_axis_tuser,  // opcode[1:0]
  output logic m_axis_tvalid,
  input wire logic m_axis_tready,
  output logic [31:0] m_axis_tdata,     // kind[2:0], slot[6:3], slot_record[26:7]
  output logic m_axis_tlast
);
  icr_pkg::cmd_t s_cmd, q_cmd;
  icr_pkg::res_t res;
  logic q_valid, q_ready;

  assign s_cmd.op = s_axis_tuser;
  assign s_cmd.rec = s_axis_tdata[19:0];

  icr_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready), .s_cmd_i(s_cmd),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );
  icr_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_res_o(res)
  );

  assign m_axis_tdata = {5'd0, res.rec, res.slot, res.kind};
  assign m_axis_tlast = res.last;
endmodule
`default_nettype wire

### tb/tb_inode_cache_replacement_top.sv
// Testbench of the inode cache replacement engine: random and directed commands, result check
`default_nettype none
module tb_inode_cache_replacement_top;
  typedef struct packed {
    logic [1:0] op;
    logic [icr_pkg::RecW-1:0] rec;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [icr_pkg::SlotW-1:0] slot;
    logic [icr_pkg::RecW-1:0] rec;
    logic last;
  } cache_res_t;

  localparam int MaxCycles = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tlast;

  inode_cache_replacement_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  cmd_item_t pending_cmds[$];
  cache_res_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 0;
  bit src_hold = 0;
  int sink_hold = 0;

  logic shadow_valid[icr_pkg::Slots];
  logic [icr_pkg::RecW-1:0] shadow_tag[icr_pkg::Slots];
  logic [icr_pkg::AgeW-1:0] shadow_age[icr_pkg::Slots];
  logic [icr_pkg::AgeW-1:0] use_count;

  function automatic void push_res(logic [2:0] k, int s, logic [icr_pkg::RecW-1:0] r);
    cache_res_t e;
    e.kind = k; e.slot = s[icr_pkg::SlotW-1:0]; e.rec = r; e.last = 1'b0;
    expected_results.push_back(e);
  endfunction

  function automatic void mark_last();
    cache_res_t e;
    e = expected_results.pop_back();
    e.last = 1'b1;
    expected_results.push_back(e);
  endfunction

  function automatic void place_record(logic [icr_pkg::RecW-1:0] r, logic [2:0] k);
    int v, oldest;
    logic [icr_pkg::RecW-1:0] blk;
    v = -1;
    oldest = 0;
    for (int i = 0; i < icr_pkg::Slots; i++) begin
      if (v < 0 && !shadow_valid[i]) v = i;
      if (shadow_age[i] < shadow_age[oldest]) oldest = i;
    end
    if (v < 0) begin
      v = oldest;
      blk = shadow_tag[v] >> icr_pkg::BlkShift;
      for (int i = 0; i < icr_pkg::Slots; i++)
        if (shadow_valid[i] && (shadow_tag[i] >> icr_pkg::BlkShift) == blk)
          push_res(icr_pkg::KindWb, i, shadow_tag[i]);
      use_count++;
    end
    shadow_valid[v] = 1'b1;
    shadow_tag[v] = r;
    shadow_age[v] = use_count;
    push_res(k, v, r);
    use_count++;
  endfunction

  function automatic void predict_cmd(cmd_item_t c);
    int hit;
    hit = -1;
    case (c.op)
      icr_pkg::OpLookup: begin
        for (int i = icr_pkg::Slots - 1; i >= 0; i--)
          if (shadow_valid[i] && shadow_tag[i] == c.rec) hit = i;
        if (hit >= 0) begin
          shadow_age[hit] = use_count;
          push_res(icr_pkg::KindHit, hit, c.rec);
        end else begin
          place_record(c.rec, icr_pkg::KindFill);
        end
        mark_last();
      end
      icr_pkg::OpInstall: begin
        place_record(c.rec, icr_pkg::KindInst);
        mark_last();
      end
      icr_pkg::OpFlush: begin
        for (int i = 0; i < icr_pkg::Slots; i++)
          if (shadow_valid[i]) push_res(icr_pkg::KindWb, i, shadow_tag[i]);
        push_res(icr_pkg::KindFlush, 0, '0);
        mark_last();
      end
      default: ;
    endcase
  endfunction

  function automatic cmd_item_t mk(logic [1:0] op, logic [icr_pkg::RecW-1:0] rec);
    cmd_item_t c;
    c.op = op; c.rec = rec;
    return c;
  endfunction

  // handshake seen at rising edge, registered for the driver
  logic acc_seen;
  always @(posedge clk_i) acc_seen <= s_axis_tvalid && s_axis_tready;

  // driver
  int src_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (acc_seen) begin
        predict_cmd(mk(s_axis_tuser, s_axis_tdata[icr_pkg::RecW-1:0]));
        void'(pending_cmds.pop_front());
        src_gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) src_gap = 0;
      end
      if (!s_axis_tvalid || acc_seen) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!src_hold && pending_cmds.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= pending_cmds[0].op;
          s_axis_tdata <= {4'b0, pending_cmds[0].rec};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready
  int sink_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        sink_gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) sink_gap = 0;
        m_axis_tready <= (sink_gap == 0);
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= (sink_gap == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cache_res_t got, want;
    cycles++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tdata[2:0];
      got.slot = m_axis_tdata[6:3];
      got.rec = m_axis_tdata[26:7];
      got.last = m_axis_tlast;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: expected no result, got %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        if (got.kind != want.kind || got.slot != want.slot || got.rec != want.rec ||
            got.last != want.last) begin
          errors++;
          $display("%0t: expected kind %0d slot %0d rec %h last %0d, got kind %0d slot %0d rec %h last %0d",
                   $time, want.kind, want.slot, want.rec, want.last,
                   got.kind, got.slot, got.rec, got.last);
        end
      end
    end
    if (cycles > MaxCycles) begin
      $display("tb_inode_cache_replacement_top: done, errors");
      $finish;
    end
  end

  function automatic logic [icr_pkg::RecW-1:0] rand_rec(int mode);
    if (mode == 0) return icr_pkg::RecW'($urandom_range(0, 47));
    return icr_pkg::RecW'($urandom);
  endfunction

  initial begin
    int r, n;
    logic [1:0] op;
    for (int i = 0; i < icr_pkg::Slots; i++) begin
      shadow_valid[i] = 1'b0; shadow_tag[i] = '0; shadow_age[i] = '0;
    end
    use_count = 1;
    // directed: extremes, every opcode, duplicates, block writeback, flush
    pending_cmds.push_back(mk(icr_pkg::OpFlush, '0));
    pending_cmds.push_back(mk(icr_pkg::OpLookup, 20'h00000));
    pending_cmds.push_back(mk(icr_pkg::OpLookup, 20'hFFFFF));
    pending_cmds.push_back(mk(icr_pkg::OpLookup, 20'h00000));
    pending_cmds.push_back(mk(icr_pkg::OpInstall, 20'hFFFFF));
    pending_cmds.push_back(mk(icr_pkg::OpLookup, 20'hFFFFF));
    pending_cmds.push_back(mk(icr_pkg::OpUnused, 20'hAAAAA));
    pending_cmds.push_back(mk(icr_pkg::OpUnused, 20'h55555));
    for (int i = 1; i <= 13; i++)
      pending_cmds.push_back(mk(icr_pkg::OpInstall, icr_pkg::RecW'(i)));
    pending_cmds.push_back(mk(icr_pkg::OpLookup, 20'h12345));
    pending_cmds.push_back(mk(icr_pkg::OpInstall, 20'h55555));
    pending_cmds.push_back(mk(icr_pkg::OpFlush, '0));
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    // random, interleaved with the pressure phases
    for (int k = 0; k < 106; k++) begin
      if (k == 20) begin
        wait (pending_cmds.size() == 0);
        @(negedge clk_i) sink_hold = 300;
      end
      if (k == 70) begin
        wait (pending_cmds.size() == 0);
        src_hold = 1;
        wait (expected_results.size() == 0 && !s_axis_tvalid);
        repeat (60) @(posedge clk_i);
        src_hold = 0;
      end
      r = $urandom_range(0, 9);
      op = (r < 6) ? icr_pkg::OpLookup : (r < 8) ? icr_pkg::OpInstall
          : (r == 8) ? icr_pkg::OpFlush : icr_pkg::OpUnused;
      n = $urandom_range(0, 3);
      pending_cmds.push_back(mk(op, rand_rec(n == 0 ? 1 : 0)));
    end
    wait (pending_cmds.size() == 0 && !s_axis_tvalid);
    wait (expected_results.size() == 0);
    repeat (80) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_inode_cache_replacement_top: done, clean");
    end else begin
      $display("tb_inode_cache_replacement_top: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
